// File: design/zero_run_literal_decoder_unit_assert.svh
// Assertion macros shared by the zero-run literal decoder RTL.
`ifndef ZERO_RUN_LITERAL_DECODER_UNIT_ASSERT_SVH
`define ZERO_RUN_LITERAL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ZRLD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ZRLD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/zrld_pkg.sv
// Package: widths and control-byte class codes of the zero-run literal decoder.
`default_nettype none

package zrld_pkg;

    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int COUNT_W = 6;

    localparam logic [1:0] CLASS_ONE  = 2'b00;
    localparam logic [1:0] CLASS_TWO  = 2'b01;
    localparam logic [1:0] CLASS_FOUR = 2'b10;
    localparam logic [1:0] CLASS_RUN  = 2'b11;

    localparam logic [RUN_W-1:0] LIT_ONE  = RUN_W'(1);
    localparam logic [RUN_W-1:0] LIT_TWO  = RUN_W'(2);
    localparam logic [RUN_W-1:0] LIT_FOUR = RUN_W'(4);

endpackage

`default_nettype wire

// File: design/zrld_if.sv
// Interfaces: compressed byte channel and decoded run channel.
`default_nettype none

interface zrld_byte_if
    import zrld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface zrld_run_if
    import zrld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_value;
    logic [RUN_W-1:0]  run_length;
    logic              last_of_input;

    modport source (output valid, output out_value, output run_length,
                    output last_of_input, input ready);
    modport sink   (input valid, input out_value, input run_length,
                    input last_of_input, output ready);
endinterface

`default_nettype wire

// File: design/zero_run_literal_decoder_unit.sv
// Top level: zero-run / literal stream decoder.
//
// Channel stream carries compressed bytes; channel result carries decoded runs
// (out_value, run_length, last_of_input). Both use valid/ready; a transaction
// completes at a rising edge with valid and ready high.
// A byte taken while no literals are pending is a control byte: it loads the
// group size and the trailing zero-run length and yields no result.
// Each later byte is a literal, sent with run_length 1. The last literal of a
// group with a zero run is followed by a second result: out_value 0,
// run_length 1..64, last_of_input 1.
// A literal goes through the input register and then the result register.
// Throughput: one byte per cycle while result is not stalled; a byte that causes
// two results holds the input stage while the zero run goes out.
// Reset clears the group state (next byte is a control byte) and empties
// both stages. When the receiver stalls, the result register holds, the input
// register still takes one byte, and stream.ready then drops.
`default_nettype none

module zero_run_literal_decoder_unit
    import zrld_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    zrld_byte_if.sink    stream,
    zrld_run_if.source   result
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [RUN_W-1:0]  literals_left_reg, literals_left_next;
    logic [RUN_W-1:0]  zeros_after_reg, zeros_after_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_value_reg, out_value_next;
    logic [RUN_W-1:0]  run_length_reg, run_length_next;
    logic              out_last_reg, out_last_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [RUN_W-1:0]  pend_run_reg, pend_run_next;

    logic              out_free;
    logic              advance;
    logic              is_literal;
    logic [RUN_W-1:0]  lit_dec;
    logic              zero_run;
    logic [RUN_W-1:0]  count;

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free && !pend_valid_reg;
    assign stream.ready = !in_valid_reg || advance;

    assign is_literal = (literals_left_reg != '0);
    assign lit_dec    = literals_left_reg - RUN_W'(1);
    assign zero_run   = is_literal && (lit_dec == '0) && (zeros_after_reg != '0);
    assign count      = RUN_W'(in_byte_reg[COUNT_W-1:0]) + RUN_W'(1);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.in_byte;
        end
    end

    // Group state update.
    always_comb
    begin
        literals_left_next = literals_left_reg;
        zeros_after_next   = zeros_after_reg;
        if (advance)
        begin
            if (is_literal)
            begin
                literals_left_next = lit_dec;
                if (zero_run)
                begin
                    zeros_after_next = '0;
                end
            end
            else
            begin
                unique case (in_byte_reg[BYTE_W-1:BYTE_W-2])
                    CLASS_ONE:
                    begin
                        literals_left_next = LIT_ONE;
                        zeros_after_next   = count;
                    end
                    CLASS_TWO:
                    begin
                        literals_left_next = LIT_TWO;
                        zeros_after_next   = count;
                    end
                    CLASS_FOUR:
                    begin
                        literals_left_next = LIT_FOUR;
                        zeros_after_next   = count;
                    end
                    CLASS_RUN:
                    begin
                        literals_left_next = count;
                        zeros_after_next   = '0;
                    end
                    default:
                    begin
                        literals_left_next = literals_left_reg;
                        zeros_after_next   = zeros_after_reg;
                    end
                endcase
            end
        end
    end

    // Result register and pending zero run.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        run_length_next = run_length_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_run_next   = pend_run_reg;
        if (out_free)
        begin
            priority if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                run_length_next = pend_run_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (advance && is_literal)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = in_byte_reg;
                run_length_next = RUN_W'(1);
                out_last_next   = !zero_run;
                pend_valid_next = zero_run;
                pend_run_next   = zeros_after_reg;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            literals_left_reg <= '0;
            zeros_after_reg   <= '0;
            out_valid_reg     <= 1'b0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            literals_left_reg <= literals_left_next;
            zeros_after_reg   <= zeros_after_next;
            out_valid_reg     <= out_valid_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        run_length_reg <= run_length_next;
        out_last_reg   <= out_last_next;
        pend_run_reg   <= pend_run_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.out_value     = out_value_reg;
    assign result.run_length    = run_length_reg;
    assign result.last_of_input = out_last_reg;

`include "zero_run_literal_decoder_unit_assert.svh"

    `ZRLD_ASSERT_SAME(a_pend_behind_literal, pend_valid_reg,
        out_valid_reg && !out_last_reg, "pending zero run without its literal")
    `ZRLD_ASSERT_SAME(a_pend_ends_group, pend_valid_reg,
        literals_left_reg == '0 && zeros_after_reg == '0 && pend_run_reg != '0,
        "pending zero run while group still open")
    `ZRLD_ASSERT_SAME(a_zeros_need_literals, zeros_after_reg != '0,
        literals_left_reg != '0, "zero run length left with no literals")
    `ZRLD_ASSERT_NEXT(a_zero_run_queued, advance && zero_run,
        pend_valid_reg && out_valid_reg, "zero run not queued after last literal")

endmodule

`default_nettype wire
